// ----- rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Holds the configuration register codes, length widths and the cell types.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  // Default sizes of the pattern window and the replacement text
  localparam int MAX_PATTERN_BYTES_DEF     = 8;
  localparam int MAX_REPLACEMENT_BYTES_DEF = 8;

  // Field widths of the configuration registers and the text bytes
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES     = 2'd0,
    REG_PATTERN_LEN       = 2'd1,
    REG_REPLACEMENT_BYTES = 2'd2,
    REG_REPLACEMENT_LEN   = 2'd3
  } cfg_reg_t;

  // One queued result of the output chain
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              bvalid;
    logic              last;
  } out_entry_t;

  // Per-cell control of the output chain
  typedef struct packed {
    logic pop;        // head transaction completes this cycle
    logic load;       // new results enter the chain this cycle
    logic from_old;   // cell keeps an older result after the shift
    logic base_zero;  // new results start at the head
  } out_cell_ctrl_t;

  // Control of the window cells
  typedef struct packed {
    logic en;         // an input byte is taken this cycle
    logic shift;      // oldest byte leaves the window
  } win_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/sfr_in_if.sv -----
// ----------------------------------------------------------------------------
// sfr_in_if: input byte channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_in_if;
  import sfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfr_out_if.sv -----
// ----------------------------------------------------------------------------
// sfr_out_if: result byte channel
// Valid/ready channel carrying one output byte, its valid flag and end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_out_if;
  import sfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              out_last;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/sfr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// sfr_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_cfg_if;
  import sfr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfr_win_cell.sv -----
// ----------------------------------------------------------------------------
// sfr_win_cell: one byte slot of the sliding pattern window
// Takes the incoming byte at its fill position, compares against its pattern
// byte and shifts toward the oldest end when the window slides.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_win_cell #(
  parameter int IDX = 0
) (
  input  wire logic                       clk,
  input  wire sfr_pkg::win_ctrl_t         ctrl,
  input  wire logic [sfr_pkg::LEN_W-1:0]  fill,
  input  wire logic [sfr_pkg::BYTE_W-1:0] in_byte,
  input  wire logic [sfr_pkg::BYTE_W-1:0] pat_byte,
  input  wire logic [sfr_pkg::BYTE_W-1:0] nbr_byte,   // next cell's updated byte
  output logic      [sfr_pkg::BYTE_W-1:0] upd_byte,   // slot value with push applied
  output logic                            eq
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  // Place the new byte when this slot is the fill position
  assign upd_byte = (fill == LEN_W'(IDX)) ? in_byte : byte_r;
  assign eq       = (upd_byte == pat_byte);

  // Slide toward the oldest end or hold the pushed byte
  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.en) begin
      byte_nxt = ctrl.shift ? nbr_byte : upd_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/sfr_out_cell.sv -----
// ----------------------------------------------------------------------------
// sfr_out_cell: one slot of the output result chain
// Shifts toward the head on each completed output transaction and takes a
// new result when the burst of an input byte is appended behind the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_out_cell (
  input  wire logic                   clk,
  input  wire sfr_pkg::out_cell_ctrl_t ctrl,
  input  wire sfr_pkg::out_entry_t    nbr_q,     // entry of the next cell
  input  wire sfr_pkg::out_entry_t    new_here,  // new result when appended at head
  input  wire sfr_pkg::out_entry_t    new_prev,  // new result when appended one back
  output sfr_pkg::out_entry_t         q
);
  import sfr_pkg::*;

  out_entry_t entry_r;
  out_entry_t entry_nxt;

  // Keep an older result, or take a new one at the append position
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.from_old) begin
      if (ctrl.pop) begin
        entry_nxt = nbr_q;
      end
    end else if (ctrl.load) begin
      entry_nxt = ctrl.base_zero ? new_here : new_prev;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule

`default_nettype wire

// ----- rtl/stream_find_and_replace_core.sv -----
// ----------------------------------------------------------------------------
// stream_find_and_replace_core: streaming byte find-and-replace
// Replaces each leftmost non-overlapping pattern occurrence in a byte stream
// with the configured replacement, using a row of window cells and a row of
// output cells.
// ----------------------------------------------------------------------------
// Output: results of an accepted input byte are registered into the output cells,
//   behind any older result still queued.
// Throughput: one byte per cycle while each byte yields at most one result and the
//   output is ready; a byte yielding several results (match or end of text) holds the
//   input until the cell chain, draining one per ready cycle, holds at most one.
// Reset: synchronous active-low rst_n clears the window fill, the output
//   queue and all configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_and_replace_core #(
  parameter int MAX_PATTERN_BYTES     = sfr_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int MAX_REPLACEMENT_BYTES = sfr_pkg::MAX_REPLACEMENT_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sfr_in_if.sink    in_s,
  sfr_out_if.source out_m,
  sfr_cfg_if.sink   cfg_s
);
  import sfr_pkg::*;

  localparam int MAX_OUT   = (MAX_PATTERN_BYTES > MAX_REPLACEMENT_BYTES) ?
                             MAX_PATTERN_BYTES : MAX_REPLACEMENT_BYTES;
  localparam int OUT_DEPTH = MAX_OUT + 1;
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam int PAT_W     = MAX_PATTERN_BYTES * BYTE_W;
  localparam int REPL_W    = MAX_REPLACEMENT_BYTES * BYTE_W;

  // Configuration registers
  logic [PAT_W-1:0]  pat_r,   pat_nxt;
  logic [LEN_W-1:0]  plen_r,  plen_nxt;
  logic [REPL_W-1:0] repl_r,  repl_nxt;
  logic [LEN_W-1:0]  rlen_r,  rlen_nxt;

  // Window and output queue control
  logic [LEN_W-1:0]  fill_r,  fill_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;

  logic              cfg_wr;
  logic              in_acc;
  logic              pop;
  logic [LEN_W-1:0]  plen_eff;
  logic [LEN_W-1:0]  rlen_eff;
  logic              plen_zero;
  logic              full;
  logic              match;
  logic [LEN_W-1:0]  fill_inc;
  logic [LEN_W-1:0]  n_raw;
  logic [LEN_W-1:0]  n_fin;
  logic [CNT_W-1:0]  base;
  win_ctrl_t         win_ctrl;

  logic [BYTE_W-1:0]           upd [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] eq;
  logic [BYTE_W-1:0]           upd_pad [MAX_OUT];
  logic [MAX_OUT*BYTE_W-1:0]   repl_pad;
  out_entry_t                  burst [MAX_OUT];
  out_entry_t                  new_ext [OUT_DEPTH+1];
  out_entry_t                  q [OUT_DEPTH];

  // Handshakes
  assign cfg_s.ready = 1'b1;
  assign cfg_wr      = cfg_s.valid;
  assign in_s.ready  = (cnt_r <= CNT_W'(1));
  assign in_acc      = in_s.valid && in_s.ready;
  assign out_m.valid = (cnt_r != '0);
  assign pop         = out_m.valid && out_m.ready;

  // Clamp lengths to the configured maximums
  assign plen_eff  = (plen_r > LEN_W'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES) : plen_r;
  assign rlen_eff  = (rlen_r > LEN_W'(MAX_REPLACEMENT_BYTES)) ?
                     LEN_W'(MAX_REPLACEMENT_BYTES) : rlen_r;
  assign plen_zero = (plen_eff == '0);

  // Configuration write decode
  always_comb begin
    pat_nxt  = pat_r;
    plen_nxt = plen_r;
    repl_nxt = repl_r;
    rlen_nxt = rlen_r;
    if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_s.index))
        REG_PATTERN_BYTES:     pat_nxt  = cfg_s.data[PAT_W-1:0];
        REG_PATTERN_LEN:       plen_nxt = cfg_s.data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES: repl_nxt = cfg_s.data[REPL_W-1:0];
        REG_REPLACEMENT_LEN:   rlen_nxt = cfg_s.data[LEN_W-1:0];
      endcase
    end
  end

  // Window cells
  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN_BYTES; gi++) begin : g_win
      logic [BYTE_W-1:0] nbr;
      if (gi < MAX_PATTERN_BYTES - 1) begin : g_nbr
        assign nbr = upd[gi+1];
      end else begin : g_end
        assign nbr = '0;
      end
      sfr_win_cell #(.IDX(gi)) u_cell (
        .clk      (clk),
        .ctrl     (win_ctrl),
        .fill     (fill_r),
        .in_byte  (in_s.in_byte),
        .pat_byte (pat_r[gi*BYTE_W +: BYTE_W]),
        .nbr_byte (nbr),
        .upd_byte (upd[gi]),
        .eq       (eq[gi])
      );
    end
  endgenerate

  // Match: window full and every slot below the pattern length agrees
  assign fill_inc = fill_r + LEN_W'(1);
  assign full     = !plen_zero && (fill_inc == plen_eff);
  always_comb begin
    match = full;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if ((LEN_W'(i) < plen_eff) && !eq[i]) begin
        match = 1'b0;
      end
    end
  end

  assign win_ctrl.en    = in_acc && !plen_zero;
  assign win_ctrl.shift = full && !match;

  // Count the results of this byte
  always_comb begin
    if (plen_zero) begin
      n_raw = LEN_W'(1);
    end else if (full) begin
      if (match) begin
        n_raw = rlen_eff;
      end else begin
        n_raw = in_s.in_last ? plen_eff : LEN_W'(1);
      end
    end else begin
      n_raw = in_s.in_last ? fill_inc : '0;
    end
    n_fin = (in_s.in_last && (n_raw == '0)) ? LEN_W'(1) : n_raw;
  end

  // Pad the result sources to the burst length
  assign repl_pad = (MAX_OUT*BYTE_W)'(repl_r);
  generate
    for (gi = 0; gi < MAX_OUT; gi++) begin : g_pad
      if (gi < MAX_PATTERN_BYTES) begin : g_w
        assign upd_pad[gi] = upd[gi];
      end else begin : g_z
        assign upd_pad[gi] = '0;
      end
    end
  endgenerate

  // Build the burst: replacement, window contents, the bypassed input byte or the bare end marker
  always_comb begin
    for (int k = 0; k < MAX_OUT; k++) begin
      if (match) begin
        burst[k].data = repl_pad[k*BYTE_W +: BYTE_W];
      end else if (plen_zero) begin
        burst[k].data = (k == 0) ? in_s.in_byte : '0;
      end else begin
        burst[k].data = upd_pad[k];
      end
      burst[k].bvalid = 1'b1;
      burst[k].last   = in_s.in_last && (LEN_W'(k + 1) == n_fin);
    end
    if (n_raw == '0) begin
      burst[0].data   = '0;
      burst[0].bvalid = 1'b0;
    end
  end

  // Window fill
  always_comb begin
    fill_nxt = fill_r;
    if (cfg_wr && (cfg_reg_t'(cfg_s.index) == REG_PATTERN_LEN)) begin
      fill_nxt = '0;
    end else if (win_ctrl.en) begin
      if (match || in_s.in_last) begin
        fill_nxt = '0;
      end else if (full) begin
        fill_nxt = plen_eff - LEN_W'(1);
      end else begin
        fill_nxt = fill_inc;
      end
    end
  end

  // Output chain: append behind the queue after the head shifts
  assign base = cnt_r - CNT_W'(pop);
  always_comb begin
    cnt_nxt = base;
    if (in_acc) begin
      cnt_nxt = base + CNT_W'(n_fin);
    end
  end

  always_comb begin
    for (int k = 0; k <= OUT_DEPTH; k++) begin
      new_ext[k] = '0;
    end
    for (int k = 0; k < MAX_OUT; k++) begin
      new_ext[k+1] = burst[k];
    end
  end

  generate
    for (gi = 0; gi < OUT_DEPTH; gi++) begin : g_out
      out_cell_ctrl_t ctrl;
      out_entry_t     nbr;
      if (gi < OUT_DEPTH - 1) begin : g_nbr
        assign nbr = q[gi+1];
      end else begin : g_end
        assign nbr = '0;
      end
      assign ctrl.pop       = pop;
      assign ctrl.load      = in_acc;
      assign ctrl.from_old  = (CNT_W'(gi) < base);
      assign ctrl.base_zero = (base == '0);
      sfr_out_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .nbr_q    (nbr),
        .new_here (new_ext[gi+1]),
        .new_prev (new_ext[gi]),
        .q        (q[gi])
      );
    end
  endgenerate

  // Head of the chain drives the result channel
  assign out_m.out_byte   = q[0].data;
  assign out_m.byte_valid = q[0].bvalid;
  assign out_m.out_last   = q[0].last;

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= '0;
      repl_r <= '0;
      rlen_r <= '0;
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      pat_r  <= pat_nxt;
      plen_r <= plen_nxt;
      repl_r <= repl_nxt;
      rlen_r <= rlen_nxt;
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
